// ----- hw/rtl/pba_pkg.sv -----
// Shared constants, codes and handshake structs of the bitmap page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pba_pkg;

  localparam int POOL_CPUS   = 8;
  localparam int GROUPS      = 4;
  localparam int GROUP_PAGES = 128;
  localparam int PAGE_BITS   = 12;

  localparam int ADDR_W   = 48;
  localparam int SLOT_W   = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = $clog2(WORD_W);

  localparam int WPG            = (GROUP_PAGES + WORD_W - 1) / WORD_W;
  localparam int NWORDS         = POOL_CPUS * GROUPS * WPG;
  localparam int PAGES_PER_SLOT = GROUPS * GROUP_PAGES;
  localparam int TOTAL_PAGES    = POOL_CPUS * PAGES_PER_SLOT;

  localparam int MEM_AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WPOS_W = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int OFF_W  = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
  localparam int IDX_W  = $clog2(WPG * WORD_W);

  localparam int LAST_REM = GROUP_PAGES % WORD_W;
  localparam logic [WORD_W-1:0] LAST_FILL =
      (LAST_REM == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << LAST_REM) - WORD_W'(1));

  localparam logic [ADDR_W:0] REGION_SIZE = (ADDR_W + 1)'(TOTAL_PAGES) << PAGE_BITS;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FREE_WR
  } state_e;

  typedef enum logic [2:0] {
    RES_ALLOC,
    RES_NOFREE,
    RES_RANGE,
    RES_CHECK,
    RES_ZERO
  } res_e;

  typedef struct packed {
    logic load;
    logic scan_first;
    logic scan_next;
    logic free_rd;
    logic alloc_wr;
    logic free_wr;
    logic finish;
    res_e res_kind;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic slot_ok;
    logic in_range;
    logic hit;
    logic scan_last;
  } stat_t;

endpackage

// ----- hw/rtl/pba_ctrl.sv -----
// Sequencing state machine of the bitmap page allocator.
// Depends on pba_pkg for state, command and status types.
module pba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  pba_pkg::stat_t stat_i,
  output pba_pkg::cmd_t  cmd_o
);

  pba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_kind   = pba_pkg::RES_ZERO;
    busy_o           = (state_q != pba_pkg::ST_IDLE);
    unique case (state_q)
      pba_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = pba_pkg::ST_DECODE;
        end
      end
      pba_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          pba_pkg::OP_ALLOC: begin
            if (stat_i.slot_ok) begin
              cmd_o.scan_first = 1'b1;
              state_d          = pba_pkg::ST_SCAN;
            end else begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = pba_pkg::RES_NOFREE;
              state_d        = pba_pkg::ST_IDLE;
            end
          end
          pba_pkg::OP_FREE: begin
            if (stat_i.in_range) begin
              cmd_o.free_rd = 1'b1;
              state_d       = pba_pkg::ST_FREE_WR;
            end else begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = pba_pkg::RES_RANGE;
              state_d        = pba_pkg::ST_IDLE;
            end
          end
          pba_pkg::OP_CHECK: begin
            cmd_o.finish   = 1'b1;
            cmd_o.res_kind = pba_pkg::RES_CHECK;
            state_d        = pba_pkg::ST_IDLE;
          end
          default: begin
            cmd_o.finish   = 1'b1;
            cmd_o.res_kind = pba_pkg::RES_ZERO;
            state_d        = pba_pkg::ST_IDLE;
          end
        endcase
      end
      pba_pkg::ST_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.alloc_wr = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = pba_pkg::RES_ALLOC;
          state_d        = pba_pkg::ST_IDLE;
        end else if (stat_i.scan_last) begin
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = pba_pkg::RES_NOFREE;
          state_d        = pba_pkg::ST_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      pba_pkg::ST_FREE_WR: begin
        cmd_o.free_wr  = 1'b1;
        cmd_o.finish   = 1'b1;
        cmd_o.res_kind = pba_pkg::RES_ZERO;
        state_d        = pba_pkg::ST_IDLE;
      end
      default: begin
        state_d = pba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pba_datapath.sv -----
// Datapath of the bitmap page allocator: free-bit memory, group pointers,
// scan counters, address decode and result registers. Depends on pba_pkg.
module pba_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pba_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  logic [pba_pkg::OP_W-1:0]         op_i,
  input  logic [pba_pkg::SLOT_W-1:0]       cpu_slot_i,
  input  logic [pba_pkg::ADDR_W-1:0]       phys_addr_i,
  input  pba_pkg::cmd_t                    cmd_i,
  output pba_pkg::stat_t                   stat_o,
  output logic                             done_o,
  output logic [pba_pkg::STATUS_W-1:0]     status_o,
  output logic [pba_pkg::ADDR_W-1:0]       page_addr_o,
  output logic                             in_region_o
);

  function automatic logic [pba_pkg::MEM_AW-1:0] word_index(
    input logic [pba_pkg::SLOT_W-1:0] slot,
    input logic [pba_pkg::GRP_W-1:0]  grp,
    input logic [pba_pkg::WPOS_W-1:0] wpos
  );
    return pba_pkg::MEM_AW'((int'(slot) * pba_pkg::GROUPS + int'(grp)) * pba_pkg::WPG
                            + int'(wpos));
  endfunction

  function automatic logic [pba_pkg::GRP_W-1:0] grp_wrap(
    input logic [pba_pkg::GRP_W-1:0] base,
    input logic [pba_pkg::GRP_W-1:0] step
  );
    logic [pba_pkg::GRP_W:0] sum;
    sum = (pba_pkg::GRP_W + 1)'(base) + (pba_pkg::GRP_W + 1)'(step);
    if (sum >= (pba_pkg::GRP_W + 1)'(pba_pkg::GROUPS)) begin
      sum = sum - (pba_pkg::GRP_W + 1)'(pba_pkg::GROUPS);
    end
    return sum[pba_pkg::GRP_W-1:0];
  endfunction

  logic [pba_pkg::ADDR_W-1:0]     region_base_q;
  pba_pkg::op_e                   op_q;
  logic [pba_pkg::SLOT_W-1:0]     slot_q;
  logic [pba_pkg::ADDR_W-1:0]     addr_q;

  logic [pba_pkg::WORD_W-1:0]     mem [pba_pkg::NWORDS];
  logic [pba_pkg::NWORDS-1:0]     valid_q;
  logic [pba_pkg::WORD_W-1:0]     rd_data_q;
  logic                           rd_valid_q;
  logic [pba_pkg::WPOS_W-1:0]     rd_pos_q;

  logic [pba_pkg::GRP_W-1:0]      next_group_q [pba_pkg::POOL_CPUS];
  logic [pba_pkg::GRP_W-1:0]      i_q, i_nx;
  logic [pba_pkg::WPOS_W-1:0]     w_q, w_nx;

  logic [pba_pkg::MEM_AW-1:0]     free_k_q;
  logic [pba_pkg::BIT_W-1:0]      free_bit_q;

  logic                           done_q;
  logic [pba_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [pba_pkg::ADDR_W-1:0]     page_addr_q, page_addr_d;
  logic                           in_region_q, in_region_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
    end else if (cfg_we_i) begin
      region_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= pba_pkg::op_e'(op_i);
      slot_q <= cpu_slot_i;
      addr_q <= phys_addr_i;
    end
  end

  // Region bounds and free-address decode.
  logic [pba_pkg::ADDR_W:0]       region_end;
  logic                           ge_base, lt_end, le_end;
  logic [pba_pkg::ADDR_W-1:0]     diff;
  logic [pba_pkg::OFF_W-1:0]      off_free;
  logic [pba_pkg::OFF_W-1:0]      inner_free;
  logic [pba_pkg::SLOT_W-1:0]     slot_free;
  logic [pba_pkg::GRP_W-1:0]      grp_free;
  logic [pba_pkg::IDX_W-1:0]      idx_free;
  logic [pba_pkg::WPOS_W-1:0]     wpos_free;
  logic [pba_pkg::MEM_AW-1:0]     k_free;
  logic [pba_pkg::BIT_W-1:0]      bit_free;

  always_comb begin
    region_end = {1'b0, region_base_q} + pba_pkg::REGION_SIZE;
    ge_base    = (addr_q >= region_base_q);
    lt_end     = ({1'b0, addr_q} < region_end);
    le_end     = ({1'b0, addr_q} <= region_end);
    diff       = addr_q - region_base_q;
    off_free   = pba_pkg::OFF_W'(diff >> pba_pkg::PAGE_BITS);
    slot_free  = pba_pkg::SLOT_W'(off_free / pba_pkg::PAGES_PER_SLOT);
    inner_free = pba_pkg::OFF_W'(off_free % pba_pkg::PAGES_PER_SLOT);
    grp_free   = pba_pkg::GRP_W'(inner_free % pba_pkg::GROUPS);
    idx_free   = pba_pkg::IDX_W'(inner_free / pba_pkg::GROUPS);
    wpos_free  = pba_pkg::WPOS_W'(idx_free / pba_pkg::WORD_W);
    bit_free   = pba_pkg::BIT_W'(idx_free % pba_pkg::WORD_W);
    k_free     = word_index(slot_free, grp_free, wpos_free);
  end

  // Scan position: group iteration i and word w within the group.
  logic [pba_pkg::GRP_W-1:0]      start_grp, g_cur, g_nx;
  logic [pba_pkg::MEM_AW-1:0]     k_cur, k_nx;

  always_comb begin
    i_nx = i_q;
    w_nx = w_q;
    if (cmd_i.scan_first) begin
      i_nx = '0;
      w_nx = '0;
    end else if (w_q == pba_pkg::WPOS_W'(pba_pkg::WPG - 1)) begin
      i_nx = i_q + pba_pkg::GRP_W'(1);
      w_nx = '0;
    end else begin
      w_nx = w_q + pba_pkg::WPOS_W'(1);
    end
    start_grp = next_group_q[slot_q];
    g_cur     = grp_wrap(start_grp, i_q);
    g_nx      = grp_wrap(start_grp, i_nx);
    k_cur     = word_index(slot_q, g_cur, w_q);
    k_nx      = word_index(slot_q, g_nx, w_nx);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_first || cmd_i.scan_next) begin
      i_q <= i_nx;
      w_q <= w_nx;
    end
    if (cmd_i.free_rd) begin
      free_k_q   <= k_free;
      free_bit_q <= bit_free;
    end
  end

  // Free-bit memory; an entry never written reads as its reset fill.
  logic                           rd_en, wr_en;
  logic [pba_pkg::MEM_AW-1:0]     rd_addr, wr_addr;
  logic [pba_pkg::WPOS_W-1:0]     rd_pos;
  logic [pba_pkg::WORD_W-1:0]     wr_data, eff_word, onehot;
  logic [pba_pkg::BIT_W-1:0]      low_bit;

  always_comb begin
    rd_en    = cmd_i.free_rd || cmd_i.scan_first || cmd_i.scan_next;
    rd_addr  = cmd_i.free_rd ? k_free : k_nx;
    rd_pos   = cmd_i.free_rd ? wpos_free : w_nx;
    if (rd_valid_q) begin
      eff_word = rd_data_q;
    end else if (rd_pos_q == pba_pkg::WPOS_W'(pba_pkg::WPG - 1)) begin
      eff_word = pba_pkg::LAST_FILL;
    end else begin
      eff_word = '1;
    end
    onehot  = eff_word & (~eff_word + pba_pkg::WORD_W'(1));
    low_bit = '0;
    for (int n = 0; n < pba_pkg::WORD_W; n++) begin
      if (onehot[n]) begin
        low_bit = low_bit | pba_pkg::BIT_W'(n);
      end
    end
    wr_en   = cmd_i.alloc_wr || cmd_i.free_wr;
    wr_addr = cmd_i.free_wr ? free_k_q : k_cur;
    wr_data = cmd_i.free_wr ? (eff_word | (pba_pkg::WORD_W'(1) << free_bit_q))
                            : (eff_word & ~onehot);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q  <= mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      rd_pos_q   <= rd_pos;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < pba_pkg::POOL_CPUS; s++) begin
        next_group_q[s] <= '0;
      end
    end else if (cmd_i.alloc_wr) begin
      if (g_cur == pba_pkg::GRP_W'(pba_pkg::GROUPS - 1)) begin
        next_group_q[slot_q] <= '0;
      end else begin
        next_group_q[slot_q] <= g_cur + pba_pkg::GRP_W'(1);
      end
    end
  end

  // Allocated page address.
  logic [pba_pkg::IDX_W-1:0]      idx_alloc;
  logic [pba_pkg::OFF_W-1:0]      off_alloc;
  logic [pba_pkg::ADDR_W-1:0]     addr_alloc;

  always_comb begin
    idx_alloc  = pba_pkg::IDX_W'(int'(w_q) * pba_pkg::WORD_W + int'(low_bit));
    off_alloc  = pba_pkg::OFF_W'(int'(slot_q) * pba_pkg::PAGES_PER_SLOT
                                 + int'(idx_alloc) * pba_pkg::GROUPS + int'(g_cur));
    addr_alloc = region_base_q + (pba_pkg::ADDR_W'(off_alloc) << pba_pkg::PAGE_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_comb begin
    status_d    = pba_pkg::STATUS_OK;
    page_addr_d = '0;
    in_region_d = 1'b0;
    case (cmd_i.res_kind)
      pba_pkg::RES_ALLOC:  page_addr_d = addr_alloc;
      pba_pkg::RES_NOFREE: status_d    = pba_pkg::STATUS_NOFREE;
      pba_pkg::RES_RANGE:  status_d    = pba_pkg::STATUS_RANGE;
      pba_pkg::RES_CHECK:  in_region_d = ge_base && le_end;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q    <= status_d;
      page_addr_q <= page_addr_d;
      in_region_q <= in_region_d;
    end
  end

  always_comb begin
    stat_o.op        = op_q;
    stat_o.slot_ok   = (int'(slot_q) < pba_pkg::POOL_CPUS);
    stat_o.in_range  = ge_base && lt_end;
    stat_o.hit       = (eff_word != '0);
    stat_o.scan_last = (i_q == pba_pkg::GRP_W'(pba_pkg::GROUPS - 1)) &&
                       (w_q == pba_pkg::WPOS_W'(pba_pkg::WPG - 1));
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign page_addr_o = page_addr_q;
  assign in_region_o = in_region_q;

endmodule

// ----- hw/rtl/per_cpu_bitmap_page_allocator.sv -----
// Top level of the per-CPU bitmap page allocator.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
//
// A command is transferred at a rising edge where start is high and busy is
// low; op_i, cpu_slot_i and phys_addr_i are sampled then. Each command gives
// exactly one result on status_o, page_addr_o and in_region_o, shown for one
// cycle with done_o high; the receiver cannot stall it.
// Check, the unused op and a free outside the region end in the decode state,
// a free inside the region reads its map word and then writes it back, and
// an allocation scans the 64-bit map words of its slot (1 to 8 here) until
// it finds a free page or has scanned them all; the scan reads one word of
// the free-bit memory per cycle through its single registered read port.
// busy falls as done_o rises, so the next command can be taken in that cycle.
// The region base is written with cfg_we_i and cfg_wdata_i; the user must do
// so only while idle, and the block itself does not enforce this.
// After reset every page is free, each group pointer is zero and the region
// base is zero; no clearing pass is needed, the block is ready at once.
module per_cpu_bitmap_page_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pba_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [pba_pkg::OP_W-1:0]     op_i,
  input  logic [pba_pkg::SLOT_W-1:0]   cpu_slot_i,
  input  logic [pba_pkg::ADDR_W-1:0]   phys_addr_i,
  output logic                         done_o,
  output logic [pba_pkg::STATUS_W-1:0] status_o,
  output logic [pba_pkg::ADDR_W-1:0]   page_addr_o,
  output logic                         in_region_o
);

  pba_pkg::cmd_t  cmd;
  pba_pkg::stat_t stat;

  pba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  pba_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .cpu_slot_i  (cpu_slot_i),
    .phys_addr_i (phys_addr_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .page_addr_o (page_addr_o),
    .in_region_o (in_region_o)
  );

endmodule
